>>> hdl/assert_macros.svh
// assertion macros shared by the checker files
// needs nothing else; every macro takes its own clock and active-low reset

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hdl/rbs_pkg.sv
// shared constants and register index codes for the ray/box slab test
// used by the top level and its checker

package rbs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } reg_idx_e;

endpackage

>>> hdl/rbs_qscale.sv
// fixed-point rescale of a full product: drop the fraction bits rounding
// toward zero, then saturate to the signed coordinate range; no dependencies

module rbs_qscale #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int PW = 65
) (
  input  logic signed [PW-1:0] prod_i,
  output logic signed [W-1:0]  res_o
);

  localparam int EW = PW + W;

  logic signed [EW-1:0] ext;
  logic signed [EW-1:0] shf;
  logic signed [EW-1:0] rnd;
  logic signed [EW-1:0] maxv;
  logic signed [EW-1:0] minv;
  logic                 corr;

  always_comb begin
    ext  = EW'(prod_i);
    shf  = ext >>> F;
    // negative values with dropped fraction bits move one step back to zero
    corr = prod_i[PW-1] && (|prod_i[F-1:0]);
    rnd  = shf + $signed(EW'(corr));
    maxv = EW'($signed({1'b0, {(W-1){1'b1}}}));
    minv = EW'($signed({1'b1, {(W-1){1'b0}}}));
    if (rnd > maxv) begin
      res_o = maxv[W-1:0];
    end else if (rnd < minv) begin
      res_o = minv[W-1:0];
    end else begin
      res_o = rnd[W-1:0];
    end
  end

endmodule

>>> hdl/rbs_tdist.sv
// slab distance stages: plane selection and subtract, multiply by the
// reciprocal, rescale; uses rbs_qscale

module rbs_tdist #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] org_i     [3],
  input  logic signed [W-1:0] dir_i     [3],
  input  logic signed [W-1:0] inv_i     [3],
  input  logic        [2:0]   neg_i,
  input  logic signed [W-1:0] box_min_i [3],
  input  logic signed [W-1:0] box_max_i [3],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [W-1:0] org_o     [3],
  output logic signed [W-1:0] dir_o     [3],
  output logic signed [W-1:0] ta_o      [3],
  output logic signed [W-1:0] tb_o      [3]
);

  localparam int PW = 2 * W + 1;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  // stage a: plane minus origin, exact
  logic signed [W-1:0] near_pl [3];
  logic signed [W-1:0] far_pl  [3];
  logic signed [W:0]   dn_d    [3];
  logic signed [W:0]   df_d    [3];
  logic signed [W:0]   dn_q    [3];
  logic signed [W:0]   df_q    [3];
  logic signed [W-1:0] inv_a_q [3];
  logic signed [W-1:0] org_a_q [3];
  logic signed [W-1:0] dir_a_q [3];

  // stage b: full products
  logic signed [PW-1:0] pn_d    [3];
  logic signed [PW-1:0] pf_d    [3];
  logic signed [PW-1:0] pn_q    [3];
  logic signed [PW-1:0] pf_q    [3];
  logic signed [W-1:0]  org_b_q [3];
  logic signed [W-1:0]  dir_b_q [3];

  // stage c: rescaled distances
  logic signed [W-1:0] ta_d    [3];
  logic signed [W-1:0] tb_d    [3];
  logic signed [W-1:0] ta_q    [3];
  logic signed [W-1:0] tb_q    [3];
  logic signed [W-1:0] org_c_q [3];
  logic signed [W-1:0] dir_c_q [3];

  assign rdy[2] = !vld_q[2] || out_ready_i;
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      near_pl[k] = neg_i[k] ? box_max_i[k] : box_min_i[k];
      far_pl[k]  = neg_i[k] ? box_min_i[k] : box_max_i[k];
      dn_d[k]    = (W+1)'(near_pl[k]) - (W+1)'(org_i[k]);
      df_d[k]    = (W+1)'(far_pl[k]) - (W+1)'(org_i[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pn_d[k] = PW'(dn_q[k]) * PW'(inv_a_q[k]);
      pf_d[k] = PW'(df_q[k]) * PW'(inv_a_q[k]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_scale
    rbs_qscale #(.W(W), .F(F), .PW(PW)) u_scale_a (
      .prod_i (pn_q[g]),
      .res_o  (ta_d[g])
    );
    rbs_qscale #(.W(W), .F(F), .PW(PW)) u_scale_b (
      .prod_i (pf_q[g]),
      .res_o  (tb_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      dn_q    <= dn_d;
      df_q    <= df_d;
      inv_a_q <= inv_i;
      org_a_q <= org_i;
      dir_a_q <= dir_i;
    end
    if (rdy[1] && vld_q[0]) begin
      pn_q    <= pn_d;
      pf_q    <= pf_d;
      org_b_q <= org_a_q;
      dir_b_q <= dir_a_q;
    end
    if (rdy[2] && vld_q[1]) begin
      ta_q    <= ta_d;
      tb_q    <= tb_d;
      org_c_q <= org_b_q;
      dir_c_q <= dir_b_q;
    end
  end

  assign org_o = org_c_q;
  assign dir_o = dir_c_q;
  assign ta_o  = ta_q;
  assign tb_o  = tb_q;

endmodule

>>> hdl/rbs_interval.sv
// interval narrowing: x pair opens the interval, y then z narrow it, a miss
// is flagged as soon as it empties; one stage per narrowing step

module rbs_interval #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] org_i [3],
  input  logic signed [W-1:0] dir_i [3],
  input  logic signed [W-1:0] ta_i  [3],
  input  logic signed [W-1:0] tb_i  [3],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [W-1:0] org_o [3],
  output logic signed [W-1:0] dir_o [3],
  output logic                hit_o,
  output logic signed [W-1:0] t_near_o,
  output logic signed [W-1:0] t_far_o
);

  logic [1:0] vld_q;
  logic [1:0] rdy;

  logic                hit1_d;
  logic signed [W-1:0] tn1_d;
  logic signed [W-1:0] tf1_d;
  logic                hit1_q;
  logic signed [W-1:0] tn1_q;
  logic signed [W-1:0] tf1_q;
  logic signed [W-1:0] tzn_q;
  logic signed [W-1:0] tzf_q;
  logic signed [W-1:0] org1_q [3];
  logic signed [W-1:0] dir1_q [3];

  logic                hit2_d;
  logic signed [W-1:0] tn2_d;
  logic signed [W-1:0] tf2_d;
  logic                hit2_q;
  logic signed [W-1:0] tn2_q;
  logic signed [W-1:0] tf2_q;
  logic signed [W-1:0] org2_q [3];
  logic signed [W-1:0] dir2_q [3];

  assign rdy[1] = !vld_q[1] || out_ready_i;
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  // strict compares: touching intervals still count as a hit
  always_comb begin
    hit1_d = !((ta_i[0] > tb_i[1]) || (ta_i[1] > tb_i[0]));
    tn1_d  = (ta_i[1] > ta_i[0]) ? ta_i[1] : ta_i[0];
    tf1_d  = (tb_i[1] < tb_i[0]) ? tb_i[1] : tb_i[0];
  end

  // after a miss on y the z results no longer matter
  always_comb begin
    hit2_d = hit1_q && !((tn1_q > tzf_q) || (tzn_q > tf1_q));
    tn2_d  = (tzn_q > tn1_q) ? tzn_q : tn1_q;
    tf2_d  = (tzf_q < tf1_q) ? tzf_q : tf1_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      hit1_q <= hit1_d;
      tn1_q  <= tn1_d;
      tf1_q  <= tf1_d;
      tzn_q  <= ta_i[2];
      tzf_q  <= tb_i[2];
      org1_q <= org_i;
      dir1_q <= dir_i;
    end
    if (rdy[1] && vld_q[0]) begin
      hit2_q <= hit2_d;
      tn2_q  <= tn2_d;
      tf2_q  <= tf2_d;
      org2_q <= org1_q;
      dir2_q <= dir1_q;
    end
  end

  assign org_o    = org2_q;
  assign dir_o    = dir2_q;
  assign hit_o    = hit2_q;
  assign t_near_o = tn2_q;
  assign t_far_o  = tf2_q;

endmodule

>>> hdl/rbs_point.sv
// entry point stages: direction times t_near, rescale, add origin with
// saturation; zeroes every field on a miss; holds the output register

module rbs_point #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] org_i [3],
  input  logic signed [W-1:0] dir_i [3],
  input  logic                hit_i,
  input  logic signed [W-1:0] t_near_i,
  input  logic signed [W-1:0] t_far_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic signed [W-1:0] point_o [3],
  output logic signed [W-1:0] t_near_o,
  output logic signed [W-1:0] t_far_o
);

  localparam int PW = 2 * W;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [PW-1:0] pr_d   [3];
  logic signed [PW-1:0] pr_q   [3];
  logic signed [W-1:0]  org1_q [3];
  logic                 hit1_q;
  logic signed [W-1:0]  tn1_q;
  logic signed [W-1:0]  tf1_q;

  logic signed [W-1:0]  m_d    [3];
  logic signed [W-1:0]  m_q    [3];
  logic signed [W-1:0]  org2_q [3];
  logic                 hit2_q;
  logic signed [W-1:0]  tn2_q;
  logic signed [W-1:0]  tf2_q;

  logic signed [W:0]    sum    [3];
  logic signed [W-1:0]  pt_d   [3];
  logic signed [W-1:0]  tn3_d;
  logic signed [W-1:0]  tf3_d;
  logic signed [W-1:0]  pt_q   [3];
  logic                 hit3_q;
  logic signed [W-1:0]  tn3_q;
  logic signed [W-1:0]  tf3_q;

  assign rdy[2] = !vld_q[2] || out_ready_i;
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_d[k] = PW'(dir_i[k]) * PW'(t_near_i);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_scale
    rbs_qscale #(.W(W), .F(F), .PW(PW)) u_scale (
      .prod_i (pr_q[g]),
      .res_o  (m_d[g])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = (W+1)'(org2_q[k]) + (W+1)'(m_q[k]);
      // top two bits differ only when the sum left the coordinate range
      if (sum[k][W] != sum[k][W-1]) begin
        pt_d[k] = sum[k][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pt_d[k] = sum[k][W-1:0];
      end
      if (!hit2_q) pt_d[k] = '0;
    end
    tn3_d = hit2_q ? tn2_q : '0;
    tf3_d = hit2_q ? tf2_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      pr_q   <= pr_d;
      org1_q <= org_i;
      hit1_q <= hit_i;
      tn1_q  <= t_near_i;
      tf1_q  <= t_far_i;
    end
    if (rdy[1] && vld_q[0]) begin
      m_q    <= m_d;
      org2_q <= org1_q;
      hit2_q <= hit1_q;
      tn2_q  <= tn1_q;
      tf2_q  <= tf1_q;
    end
    if (rdy[2] && vld_q[1]) begin
      pt_q   <= pt_d;
      hit3_q <= hit2_q;
      tn3_q  <= tn3_d;
      tf3_q  <= tf3_d;
    end
  end

  assign hit_o    = hit3_q;
  assign point_o  = pt_q;
  assign t_near_o = tn3_q;
  assign t_far_o  = tf3_q;

endmodule

>>> hdl/ray_box_slab_intersect.sv
// top level of the ray/box slab test: box registers and the eight-stage pipe
// uses rbs_pkg, rbs_tdist, rbs_interval and rbs_point

// Tests one ray per request against the axis-aligned box held in the six box
// registers, all values signed fixed point (COORD_WIDTH bits, FRAC_BITS
// fraction bits). A new request can be taken every clock cycle unless the pipe
// is full and the output stalls. Each one passes through eight register
// stages, one per dependent step (subtract, multiply, rescale, two interval
// steps, multiply, rescale, add), and its result shows on the output from the
// last of them. Output stall holds only the stages that are full, so the pipe
// keeps filling bubbles while a result waits. Write the box registers only
// while no request is in flight.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]          cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]   origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]   origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]   origin_z_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]   dir_z_i,
  input  logic signed [COORD_WIDTH-1:0]   inv_dir_x_i,
  input  logic signed [COORD_WIDTH-1:0]   inv_dir_y_i,
  input  logic signed [COORD_WIDTH-1:0]   inv_dir_z_i,
  input  logic                            neg_x_i,
  input  logic                            neg_y_i,
  input  logic                            neg_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic signed [COORD_WIDTH-1:0]   point_x_o,
  output logic signed [COORD_WIDTH-1:0]   point_y_o,
  output logic signed [COORD_WIDTH-1:0]   point_z_o,
  output logic signed [COORD_WIDTH-1:0]   t_near_o,
  output logic signed [COORD_WIDTH-1:0]   t_far_o
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] box_min_q [3];
  logic signed [W-1:0] box_max_q [3];

  logic signed [W-1:0] org_in [3];
  logic signed [W-1:0] dir_in [3];
  logic signed [W-1:0] inv_in [3];
  logic        [2:0]   neg_in;

  logic                td_in_ready;
  logic                td_valid;
  logic                td_ready;
  logic signed [W-1:0] td_org [3];
  logic signed [W-1:0] td_dir [3];
  logic signed [W-1:0] td_ta  [3];
  logic signed [W-1:0] td_tb  [3];

  logic                iv_valid;
  logic                iv_ready;
  logic signed [W-1:0] iv_org [3];
  logic signed [W-1:0] iv_dir [3];
  logic                iv_hit;
  logic signed [W-1:0] iv_tn;
  logic signed [W-1:0] iv_tf;

  logic signed [W-1:0] pt [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '{default: '0};
      box_max_q <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (rbs_pkg::reg_idx_e'(cfg_idx_i))
        rbs_pkg::REG_BOX_MIN_X: box_min_q[0] <= cfg_wdata_i;
        rbs_pkg::REG_BOX_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        rbs_pkg::REG_BOX_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        rbs_pkg::REG_BOX_MAX_X: box_max_q[0] <= cfg_wdata_i;
        rbs_pkg::REG_BOX_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        rbs_pkg::REG_BOX_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign org_in[0] = origin_x_i;
  assign org_in[1] = origin_y_i;
  assign org_in[2] = origin_z_i;
  assign dir_in[0] = dir_x_i;
  assign dir_in[1] = dir_y_i;
  assign dir_in[2] = dir_z_i;
  assign inv_in[0] = inv_dir_x_i;
  assign inv_in[1] = inv_dir_y_i;
  assign inv_in[2] = inv_dir_z_i;
  assign neg_in    = {neg_z_i, neg_y_i, neg_x_i};

  rbs_tdist #(.W(W), .F(FRAC_BITS)) u_tdist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (td_in_ready),
    .org_i       (org_in),
    .dir_i       (dir_in),
    .inv_i       (inv_in),
    .neg_i       (neg_in),
    .box_min_i   (box_min_q),
    .box_max_i   (box_max_q),
    .out_valid_o (td_valid),
    .out_ready_i (td_ready),
    .org_o       (td_org),
    .dir_o       (td_dir),
    .ta_o        (td_ta),
    .tb_o        (td_tb)
  );

  rbs_interval #(.W(W)) u_interval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (td_valid),
    .in_ready_o  (td_ready),
    .org_i       (td_org),
    .dir_i       (td_dir),
    .ta_i        (td_ta),
    .tb_i        (td_tb),
    .out_valid_o (iv_valid),
    .out_ready_i (iv_ready),
    .org_o       (iv_org),
    .dir_o       (iv_dir),
    .hit_o       (iv_hit),
    .t_near_o    (iv_tn),
    .t_far_o     (iv_tf)
  );

  rbs_point #(.W(W), .F(FRAC_BITS)) u_point (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (iv_valid),
    .in_ready_o  (iv_ready),
    .org_i       (iv_org),
    .dir_i       (iv_dir),
    .hit_i       (iv_hit),
    .t_near_i    (iv_tn),
    .t_far_i     (iv_tf),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .hit_o       (hit_o),
    .point_o     (pt),
    .t_near_o    (t_near_o),
    .t_far_o     (t_far_o)
  );

  assign in_stall_o = !td_in_ready;
  assign point_x_o  = pt[0];
  assign point_y_o  = pt[1];
  assign point_z_o  = pt[2];

endmodule

>>> hdl/rbs_checker.sv
// port-level checks for the ray/box slab test, bound to the top level
// uses assert_macros.svh

`include "assert_macros.svh"

module rbs_checker #(
  parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   hit_o,
  input logic [COORD_WIDTH-1:0] point_x_o,
  input logic [COORD_WIDTH-1:0] point_y_o,
  input logic [COORD_WIDTH-1:0] point_z_o,
  input logic [COORD_WIDTH-1:0] t_near_o,
  input logic [COORD_WIDTH-1:0] t_far_o
);

  logic                     res_held;
  logic [5*COORD_WIDTH-1:0] res_data;

  assign res_held = out_valid_o && out_stall_i;
  assign res_data = {point_x_o, point_y_o, point_z_o, t_near_o, t_far_o};

  // a waiting result stays put until taken
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, res_held |=> out_valid_o)
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, res_held |=> $stable(hit_o) && $stable(res_data))

  // a miss carries no point and no distances
  `ASSERT_CLK(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o |-> res_data == '0)

  // back pressure only ever comes from the output side
  `ASSERT_NEVER(a_no_idle_stall, clk_i, rst_ni, in_stall_o && !out_stall_i)

endmodule

bind ray_box_slab_intersect rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (.*);

>>> dv/ray_box_slab_intersect_tb.sv
`timescale 1ns / 1ps
// self-checking bench for ray_box_slab_intersect: random and directed rays
// against several box settings, checked by a local slab predictor; needs rbs_pkg

module ray_box_slab_intersect_tb;

  localparam int CW             = rbs_pkg::COORD_WIDTH_DEF;
  localparam int FB             = rbs_pkg::FRAC_BITS_DEF;
  localparam int ONE            = 1 << FB;
  localparam int Q_MAX          = 32'h7fff_ffff;
  localparam int Q_MIN          = 32'h8000_0000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RAYS_PER_BOX   = 170;
  localparam int HOLD_AT        = 100;
  localparam int HOLD_LEN       = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {BOX_NORMAL, BOX_FULL, BOX_SWAPPED, BOX_WILD, BOX_FLAT} box_kind_e;

  typedef struct packed {
    logic [CW-1:0] ox, oy, oz;
    logic [CW-1:0] dx, dy, dz;
    logic [CW-1:0] ix, iy, iz;
    logic          nx, ny, nz;
  } ray_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] px, py, pz;
    logic [CW-1:0] tn, tf;
  } isect_t;

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  rbs_pkg::reg_idx_e  cfg_idx   = rbs_pkg::REG_BOX_MIN_X;
  logic [CW-1:0]      cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               out_stall = 1'b0;
  ray_t               drv_ray   = '0;
  logic               in_stall_o, out_valid_o, hit_o;
  logic [CW-1:0]      point_x_o, point_y_o, point_z_o, t_near_o, t_far_o;

  // shadow of the box registers, indexed like the register map
  logic [CW-1:0]  box_reg [6] = '{default: '0};

  ray_t           ray_q [$];
  isect_t         isect_q [$];

  logic           in_taken  = 1'b0;
  logic           out_taken = 1'b0;
  bit             in_calm   = 1'b0;
  bit             out_calm  = 1'b0;
  int             in_gap    = 0;
  int             out_wait  = 0;
  int             quiet_cycles = 0;
  int             n_rays = 0, n_results = 0, n_hits = 0, n_misses = 0;
  int             n_boxes = 0, n_bad = 0, n_unexpected = 0;

  ray_box_slab_intersect dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .origin_x_i  (drv_ray.ox),
    .origin_y_i  (drv_ray.oy),
    .origin_z_i  (drv_ray.oz),
    .dir_x_i     (drv_ray.dx),
    .dir_y_i     (drv_ray.dy),
    .dir_z_i     (drv_ray.dz),
    .inv_dir_x_i (drv_ray.ix),
    .inv_dir_y_i (drv_ray.iy),
    .inv_dir_z_i (drv_ray.iz),
    .neg_x_i     (drv_ray.nx),
    .neg_y_i     (drv_ray.ny),
    .neg_z_i     (drv_ray.nz),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .hit_o       (hit_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .t_near_o    (t_near_o),
    .t_far_o     (t_far_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // q-format multiply: magnitudes, truncate, re-sign, saturate
  function automatic longint q_mul(longint a, longint b);
    logic [127:0] prod;
    logic [63:0]  ua, ub, q, lim;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    lim  = neg ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 64'd1;
    if ((prod >> FB) > {64'd0, lim}) q = lim;
    else q = prod[FB +: 64];
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint q_sat(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic isect_t slab_predict(ray_t r);
    longint org [3], dir [3], inv [3];
    longint np, fp, ta, tb, tn, tf;
    logic   neg [3];
    bit     hit;
    isect_t res;
    org = '{longint'($signed(r.ox)), longint'($signed(r.oy)), longint'($signed(r.oz))};
    dir = '{longint'($signed(r.dx)), longint'($signed(r.dy)), longint'($signed(r.dz))};
    inv = '{longint'($signed(r.ix)), longint'($signed(r.iy)), longint'($signed(r.iz))};
    neg = '{r.nx, r.ny, r.nz};
    tn  = 0;
    tf  = 0;
    hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (hit) begin
        np = longint'($signed(neg[k] ? box_reg[3 + k] : box_reg[k]));
        fp = longint'($signed(neg[k] ? box_reg[k] : box_reg[3 + k]));
        ta = q_mul(np - org[k], inv[k]);
        tb = q_mul(fp - org[k], inv[k]);
        if (k == 0) begin
          tn = ta;
          tf = tb;
        end else if (tn > tb || ta > tf) begin
          hit = 1'b0;
        end else begin
          if (ta > tn) tn = ta;
          if (tb < tf) tf = tb;
        end
      end
    end
    res = '0;
    res.hit = hit;
    if (hit) begin
      res.px = CW'(q_sat(org[0] + q_mul(dir[0], tn)));
      res.py = CW'(q_sat(org[1] + q_mul(dir[1], tn)));
      res.pz = CW'(q_sat(org[2] + q_mul(dir[2], tn)));
      res.tn = CW'(tn);
      res.tf = CW'(tf);
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // aimed rays start near the box and point at its centre; the rest is noise
  function automatic ray_t rand_ray(bit aimed);
    longint c, o, d, iv;
    logic [CW-1:0] fo [3], fd [3], fi [3];
    logic          fn [3];
    ray_t          r;
    for (int k = 0; k < 3; k++) begin
      if (aimed) begin
        c = (longint'($signed(box_reg[k])) + longint'($signed(box_reg[3 + k]))) / 2;
        o = c + longint'($urandom_range(0, 32 * ONE)) - 16 * ONE;
        d = (c + longint'($urandom_range(0, ONE / 2)) - ONE / 4 - o) / 4;
        if (d >= 0 && d < 256) d = 256;
        if (d < 0 && d > -256) d = -256;
        iv = (longint'(1) << (2 * FB)) / d;
        fn[k] = (d < 0) ^ ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 15) == 0) begin
          // axis-parallel ray: no direction, reciprocal zero or railed
          d  = 0;
          iv = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN);
        end
        fo[k] = CW'(o);
        fd[k] = CW'(d);
        fi[k] = CW'(iv);
      end else begin
        fo[k] = rand_word();
        fd[k] = rand_word();
        fi[k] = rand_word();
        fn[k] = 1'($urandom_range(0, 1));
      end
    end
    r = '{fo[0], fo[1], fo[2], fd[0], fd[1], fd[2], fi[0], fi[1], fi[2], fn[0], fn[1], fn[2]};
    return r;
  endfunction

  task automatic push_ray(input int ox, oy, oz, dx, dy, dz, ix, iy, iz,
                          input bit nx, ny, nz);
    ray_q.push_back('{ox, oy, oz, dx, dy, dz, ix, iy, iz, nx, ny, nz});
  endtask

  // every request yields a result, so an empty store means the pipe is empty
  task automatic drain();
    while (ray_q.size() != 0 || in_valid || isect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_box(input logic [CW-1:0] lx, ly, lz, hx, hy, hz);
    logic [CW-1:0] v [6];
    v = '{lx, ly, lz, hx, hy, hz};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we     <= 1'b1;
      cfg_idx    <= rbs_pkg::reg_idx_e'(i);
      cfg_wdata  <= v[i];
      box_reg[i]  = v[i];
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
    n_boxes++;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (ray_q.size() != 0) begin
        drv_ray  <= ray_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= in_calm ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 31) == 0) in_calm <= !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold once the pipe is busy
  always @(negedge clk_i) begin
    int nw;
    if (rst_ni) begin
      if (out_taken) begin
        if (n_results == HOLD_AT) nw = HOLD_LEN;
        else nw = out_calm ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 31) == 0) out_calm <= !out_calm;
        out_wait  <= nw;
        out_stall <= (nw != 0);
      end else if (out_wait > 0) begin
        out_wait  <= out_wait - 1;
        out_stall <= (out_wait > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    isect_t e;
    isect_t got;
    bit     fire_in, fire_out;
    fire_in   = rst_ni && in_valid && !in_stall_o;
    fire_out  = rst_ni && out_valid_o && !out_stall;
    in_taken  <= fire_in;
    out_taken <= fire_out;
    if (rst_ni) begin
      quiet_cycles <= (fire_in || fire_out || cfg_we) ? 0 : quiet_cycles + 1;
      if (fire_in) begin
        isect_q.push_back(slab_predict(drv_ray));
        n_rays++;
      end
      if (fire_out) begin
        n_results++;
        got = '{hit_o, point_x_o, point_y_o, point_z_o, t_near_o, t_far_o};
        if (isect_q.size() == 0) begin
          n_unexpected++;
          if (n_bad + n_unexpected <= MAX_REPORTS)
            $display("unexpected result: hit=%0b t_near=%0d", hit_o, $signed(t_near_o));
        end else begin
          e = isect_q.pop_front();
          if (e.hit) n_hits++;
          else n_misses++;
          if (got.hit !== e.hit || got.px !== e.px || got.py !== e.py ||
              got.pz !== e.pz || got.tn !== e.tn || got.tf !== e.tf) begin
            n_bad++;
            if (n_bad + n_unexpected <= MAX_REPORTS) begin
              $display("mismatch on result %0d: expected hit=%0b p=(%0d,%0d,%0d) t=[%0d,%0d]",
                       n_results, e.hit, $signed(e.px), $signed(e.py), $signed(e.pz),
                       $signed(e.tn), $signed(e.tf));
              $display("  actual hit=%0b p=(%0d,%0d,%0d) t=[%0d,%0d]",
                       got.hit, $signed(got.px), $signed(got.py), $signed(got.pz),
                       $signed(got.tn), $signed(got.tf));
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int        lo [3], hi [3];
    int        t;
    box_kind_e plan [6];
    plan = '{BOX_NORMAL, BOX_FULL, BOX_SWAPPED, BOX_WILD, BOX_FLAT, BOX_NORMAL};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // a few rays against the box as it comes out of reset
    repeat (3) ray_q.push_back(rand_ray(1'b1));
    drain();

    // directed rays against a unit box
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    push_ray(-5 * ONE, 0, 0, ONE, 0, 0, ONE, Q_MAX, Q_MAX, 0, 0, 0);
    push_ray(5 * ONE, 0, 0, -ONE, 0, 0, -ONE, Q_MAX, Q_MAX, 1, 0, 0);
    push_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0, ONE, Q_MAX, Q_MAX, 0, 0, 0);
    // interval empties only on the last axis
    push_ray(-5 * ONE, 0, 5 * ONE, ONE, 0, 0, ONE, Q_MAX, Q_MAX, 0, 0, 0);
    // grazes an edge: entry equals exit
    push_ray(-2 * ONE, 0, 0, ONE, ONE, 0, ONE, ONE, Q_MAX, 0, 0, 0);
    // zero reciprocal everywhere
    push_ray(7 * ONE, -7 * ONE, 3 * ONE, ONE, ONE, ONE, 0, 0, 0, 0, 1, 0);
    // origin inside the box, negative entry distance
    push_ray(ONE / 2, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0);
    // plane select against the direction
    push_ray(-5 * ONE, 0, 0, ONE, 0, 0, ONE, Q_MAX, Q_MAX, 1, 0, 0);
    // railed values, saturating products and sums
    push_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 1, 1);
    push_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0);
    push_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1, 0);
    push_ray(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 0, 1);
    push_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1, 1, 1);
    push_ray(0, 0, 0, Q_MAX, Q_MIN, Q_MAX, 1, -1, 1, 0, 1, 0);
    for (int m = 0; m < 8; m++)
      push_ray(-3 * ONE, ONE / 4, -ONE / 4, ONE, ONE / 8, ONE / 8, ONE, 8 * ONE, 8 * ONE,
               m[0], m[1], m[2]);
    drain();

    // random rays over a series of box shapes
    foreach (plan[p]) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] = int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
        hi[k] = lo[k] + int'($urandom_range(0, 8 * ONE));
        case (plan[p])
          BOX_FULL: begin
            lo[k] = Q_MIN;
            hi[k] = Q_MAX;
          end
          BOX_SWAPPED: begin
            t     = lo[k];
            lo[k] = hi[k];
            hi[k] = t;
          end
          BOX_WILD: begin
            lo[k] = $urandom;
            hi[k] = $urandom;
          end
          BOX_FLAT: hi[k] = lo[k];
          default: ;
        endcase
      end
      drain();
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      repeat (RAYS_PER_BOX) ray_q.push_back(rand_ray($urandom_range(0, 6) != 0));
    end
    drain();

    if (isect_q.size() != 0) n_bad += isect_q.size();
    $display("summary: %0d rays over %0d box settings, %0d hits, %0d misses",
             n_rays, n_boxes, n_hits, n_misses);
    $display("summary: %0d mismatches, %0d unexpected results, long output hold done",
             n_bad, n_unexpected);
    if (n_bad == 0 && n_unexpected == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/rbs_pkg.sv
hdl/rbs_qscale.sv
hdl/rbs_tdist.sv
hdl/rbs_interval.sv
hdl/rbs_point.sv
hdl/ray_box_slab_intersect.sv
hdl/rbs_checker.sv
dv/ray_box_slab_intersect_tb.sv
